FILE: src/dbab_pkg.sv
// shared types, constants and helpers for the drizzle band alpha blend core
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package dbab_pkg;

  // field widths
  localparam int unsigned CNT_W      = 24;  // sample counts, Q16.8
  localparam int unsigned WGT_W      = 32;  // weight sums, Q16.16
  localparam int unsigned FAC_W      = 17;  // factors and alpha, Q0.16 with room for one
  localparam int unsigned QUO_W      = 16;  // quotient bits of a fraction below one
  localparam int unsigned DIV_CNT_W  = 4;   // step counter of the divider
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // fixed point constants
  localparam logic [FAC_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0]      THREE_Q16 = 18'd196608;
  localparam logic [50:0]      RAMP_RND  = 51'h0_8000_0000;
  localparam logic [33:0]      MUL_RND   = 34'd32768;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RST  = 24'd0;
  localparam logic [CNT_W-1:0] FULL_SAMPLES_RST = 24'd2048;
  localparam logic [FAC_W-1:0] ALPHA_CEIL_RST   = 17'd65536;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SAMPLES  = 2'd0,
    CFG_FULL_SAMPLES = 2'd1,
    CFG_ALPHA_CEIL   = 2'd2
  } cfg_idx_e;

  // operand set loaded into the shared divider
  typedef enum logic {
    DIV_RAMP = 1'b0,
    DIV_COV  = 1'b1
  } div_sel_e;

  // factor applied in one step of the product chain
  typedef enum logic [2:0] {
    FAC_RAMP = 3'd0,
    FAC_COV  = 3'd1,
    FAC_SEP  = 3'd2,
    FAC_ART  = 3'd3,
    FAC_RGN  = 3'd4
  } fac_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     in_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_t;
    logic     update;
    logic     acc_init;
    logic     acc_mul;
    fac_sel_e fac_sel;
    logic     out_load;
  } dbab_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_active;
    logic in_last;
    logic last;
    logic any_active;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dbab_status_t;

  // clamp to 1.0 in Q0.16
  function automatic logic [FAC_W-1:0] sat_one(input logic [18:0] v);
    logic [FAC_W-1:0] r;
    if (v > {2'b00, ONE_Q16}) begin
      r = ONE_Q16;
    end else begin
      r = v[FAC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/dbab_div.sv
// shared restoring divider: fraction quotient of a dividend below the divisor
// one quotient bit per cycle; uses dbab_pkg
`default_nettype none

module dbab_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]  dividend_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]  divisor_i,
  output logic      [dbab_pkg::QUO_W-1:0]  quotient_o,
  output logic                             busy_o,
  output logic                             done_o
);

  localparam logic [dbab_pkg::DIV_CNT_W-1:0] LastStep =
    dbab_pkg::DIV_CNT_W'(dbab_pkg::QUO_W - 1);

  logic [dbab_pkg::WGT_W-1:0]     rem_q, rem_d;
  logic [dbab_pkg::WGT_W-1:0]     den_q;
  logic [dbab_pkg::QUO_W-1:0]     quo_q;
  logic [dbab_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [dbab_pkg::WGT_W:0]       rem2, rem_sub;
  logic                           ge;

  // one trial subtraction per step
  always_comb begin
    rem2    = {rem_q, 1'b0};
    rem_sub = rem2 - {1'b0, den_q};
    ge      = rem2 >= {1'b0, den_q};
    rem_d   = ge ? rem_sub[dbab_pkg::WGT_W-1:0] : rem2[dbab_pkg::WGT_W-1:0];
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= LastStep;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[dbab_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

FILE: src/dbab_dp.sv
// datapath: config registers, item registers, ramp and coverage, minima,
// product chain and output register; uses dbab_pkg and dbab_div
`default_nettype none

module dbab_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [dbab_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [dbab_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // item fields
  input  wire logic                              profile_support_i,
  input  wire logic                              uniform_support_i,
  input  wire logic [dbab_pkg::CNT_W-1:0]        eff_samples_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]        uniform_weight_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]        profile_weight_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]        ext_separation_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]        ext_artifact_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]        ext_registration_i,
  input  wire logic                              last_channel_i,
  // controller link
  input  wire dbab_pkg::dbab_cmd_t               cmd_i,
  output dbab_pkg::dbab_status_t                 status_o,
  // result
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic      [dbab_pkg::FAC_W-1:0]        alpha_o,
  output logic                                   none_active_o
);

  // configuration registers
  logic [dbab_pkg::CNT_W-1:0] min_q, full_q;
  logic [dbab_pkg::FAC_W-1:0] cap_q;

  // item registers
  logic [dbab_pkg::CNT_W-1:0] x_q;
  logic [dbab_pkg::WGT_W-1:0] uw_q, pw_q;
  logic [dbab_pkg::FAC_W-1:0] sep_q, art_q, rgn_q;
  logic                       last_q;

  // ramp pipeline
  logic [dbab_pkg::QUO_W-1:0] t_q;
  logic [31:0]                sq_q;
  logic [17:0]                tri_f;
  logic [49:0]                s_q;
  logic [50:0]                rsum;
  logic [dbab_pkg::FAC_W-1:0] rmp_q;

  // accumulated state and product
  logic [dbab_pkg::FAC_W-1:0] min_ramp_q, min_cov_q, acc_q;
  logic                       any_q;
  logic [dbab_pkg::FAC_W-1:0] ramp_val, cov_val, fac, acc_d;
  logic [33:0]                mprod, mrnd;

  // output register
  logic                       out_valid_q, none_q;
  logic [dbab_pkg::FAC_W-1:0] alpha_q;

  // divider link
  logic [dbab_pkg::CNT_W-1:0] ramp_num, ramp_den;
  logic [dbab_pkg::WGT_W-1:0] div_dividend, div_divisor;
  logic [dbab_pkg::QUO_W-1:0] quo;
  logic                       div_busy, div_done;
  logic                       step_mode;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= dbab_pkg::MIN_SAMPLES_RST;
      full_q <= dbab_pkg::FULL_SAMPLES_RST;
      cap_q  <= dbab_pkg::ALPHA_CEIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dbab_pkg::CFG_MIN_SAMPLES:  min_q  <= cfg_data_i[dbab_pkg::CNT_W-1:0];
        dbab_pkg::CFG_FULL_SAMPLES: full_q <= cfg_data_i[dbab_pkg::CNT_W-1:0];
        dbab_pkg::CFG_ALPHA_CEIL:   cap_q  <= cfg_data_i[dbab_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // capture of an accepted beat, factors clamped to one
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q    <= eff_samples_i;
      uw_q   <= uniform_weight_i;
      pw_q   <= profile_weight_i;
      sep_q  <= dbab_pkg::sat_one({2'b00, ext_separation_i});
      art_q  <= dbab_pkg::sat_one({2'b00, ext_artifact_i});
      rgn_q  <= dbab_pkg::sat_one({2'b00, ext_registration_i});
      last_q <= last_channel_i;
    end
  end

  // divider operands
  assign ramp_num     = x_q - min_q;
  assign ramp_den     = full_q - min_q;
  assign div_dividend = (cmd_i.div_sel == dbab_pkg::DIV_RAMP) ? {8'd0, ramp_num} : pw_q;
  assign div_divisor  = (cmd_i.div_sel == dbab_pkg::DIV_RAMP) ? {8'd0, ramp_den} : uw_q;

  dbab_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // smoothstep t*t*(3-2t), one multiply per stage
  assign tri_f = dbab_pkg::THREE_Q16 - {1'b0, t_q, 1'b0};
  assign rsum  = {1'b0, s_q} + dbab_pkg::RAMP_RND;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_t) begin
      t_q <= quo;
    end
    sq_q  <= {16'd0, t_q} * {16'd0, t_q};
    s_q   <= {18'd0, sq_q} * {32'd0, tri_f};
    rmp_q <= dbab_pkg::sat_one(rsum[50:32]);
  end

  // ramp and coverage with their edge cases
  always_comb begin
    step_mode = full_q <= min_q;
    if (step_mode) begin
      ramp_val = (x_q >= full_q) ? dbab_pkg::ONE_Q16 : '0;
    end else if (x_q <= min_q) begin
      ramp_val = '0;
    end else if (x_q >= full_q) begin
      ramp_val = dbab_pkg::ONE_Q16;
    end else begin
      ramp_val = rmp_q;
    end
    if (uw_q == '0) begin
      cov_val = '0;
    end else if (pw_q >= uw_q) begin
      cov_val = dbab_pkg::ONE_Q16;
    end else begin
      cov_val = {1'b0, quo};
    end
  end

  // factor of the current product step
  always_comb begin
    case (cmd_i.fac_sel)
      dbab_pkg::FAC_RAMP: fac = min_ramp_q;
      dbab_pkg::FAC_COV:  fac = min_cov_q;
      dbab_pkg::FAC_SEP:  fac = sep_q;
      dbab_pkg::FAC_ART:  fac = art_q;
      dbab_pkg::FAC_RGN:  fac = rgn_q;
      default:            fac = dbab_pkg::ONE_Q16;
    endcase
    mprod = {17'd0, acc_q} * {17'd0, fac};
    mrnd  = mprod + dbab_pkg::MUL_RND;
    acc_d = dbab_pkg::sat_one({1'b0, mrnd[33:16]});
  end

  // running minima over the active channels of a pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ramp_q <= dbab_pkg::ONE_Q16;
      min_cov_q  <= dbab_pkg::ONE_Q16;
      any_q      <= 1'b0;
    end else if (cmd_i.out_load) begin
      min_ramp_q <= dbab_pkg::ONE_Q16;
      min_cov_q  <= dbab_pkg::ONE_Q16;
      any_q      <= 1'b0;
    end else if (cmd_i.update) begin
      any_q <= 1'b1;
      if (ramp_val < min_ramp_q) begin
        min_ramp_q <= ramp_val;
      end
      if (cov_val < min_cov_q) begin
        min_cov_q <= cov_val;
      end
    end
  end

  // product accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      acc_q <= dbab_pkg::sat_one({2'b00, cap_q});
    end else if (cmd_i.acc_mul) begin
      acc_q <= acc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      alpha_q <= any_q ? acc_q : '0;
      none_q  <= !any_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.in_active  = profile_support_i & uniform_support_i;
    status_o.in_last    = last_channel_i;
    status_o.last       = last_q;
    status_o.any_active = any_q;
    status_o.div_busy   = div_busy;
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign alpha_o       = alpha_q;
  assign none_active_o = none_q;

endmodule

`default_nettype wire

FILE: src/dbab_ctrl.sv
// controller: sequences capture, two divisions, minimum update, product chain
// and result hand-off; uses dbab_pkg
`default_nettype none

module dbab_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire dbab_pkg::dbab_status_t status_i,
  output dbab_pkg::dbab_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSTART,
    S_RWAIT,
    S_CSTART,
    S_CWAIT,
    S_UPDATE,
    S_PINIT,
    S_PMUL,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  dbab_pkg::fac_sel_e step_q, step_d;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_active) begin
            state_d = S_RSTART;
          end else if (status_i.in_last) begin
            state_d = status_i.any_active ? S_PINIT : S_OUT;
          end
        end
      end
      S_RSTART: state_d = S_RWAIT;
      S_RWAIT: begin
        if (status_i.div_done) begin
          state_d = S_CSTART;
        end
      end
      S_CSTART: state_d = S_CWAIT;
      S_CWAIT: begin
        if (status_i.div_done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: state_d = status_i.last ? S_PINIT : S_IDLE;
      S_PINIT: begin
        state_d = S_PMUL;
        step_d  = dbab_pkg::FAC_RAMP;
      end
      S_PMUL: begin
        if (step_q == dbab_pkg::FAC_RGN) begin
          state_d = S_OUT;
        end else begin
          step_d = dbab_pkg::fac_sel_e'(step_q + 3'd1);
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= dbab_pkg::FAC_RAMP;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.div_sel   = (state_q == S_CSTART) ? dbab_pkg::DIV_COV : dbab_pkg::DIV_RAMP;
    cmd_o.fac_sel   = step_q;
    cmd_o.in_load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_RSTART) || (state_q == S_CSTART);
    cmd_o.load_t    = (state_q == S_CSTART);
    cmd_o.update    = (state_q == S_UPDATE);
    cmd_o.acc_init  = (state_q == S_PINIT);
    cmd_o.acc_mul   = (state_q == S_PMUL);
    cmd_o.out_load  = (state_q == S_OUT) && status_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

FILE: src/drizzle_band_alpha_blend_core.sv
// Band blend alpha core. One beat on the input channel carries one color channel
// of one pixel: support flags, effective sample count, band and uniform weight
// sums, three confidence factors and a last-channel mark.
// Channels with both supports set fold a smoothstep of the sample count and the
// weight coverage into per-pixel minima. On the last channel one beat leaves on
// the output channel: the alpha ceiling times both minima times the three
// factors, clamped to one, or zero with none_active set when no channel was active.
// An active channel makes two passes through the shared one-bit-per-cycle
// divider (ramp, then coverage); an inactive one needs none. The last channel
// then runs the five-step multiply chain before the result registers; it shows
// on the output the cycle after. Configuration: cfg_we_i writes cfg_data_i to
// register cfg_index_i (0 min samples, 1 full samples, 2 alpha ceiling); the
// user must write it only while the block is idle, which the block itself does
// not enforce. Reset returns the minima to one, clears the output valid and
// restores the register defaults. A stalled receiver holds the result in the
// output register; the block keeps taking beats and only waits when the next
// result is ready. Depends on dbab_pkg, dbab_ctrl, dbab_dp.
`default_nettype none

module drizzle_band_alpha_blend_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration port
  input  wire logic                            cfg_we_i,
  input  wire logic [dbab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dbab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            profile_support_i,
  input  wire logic                            uniform_support_i,
  input  wire logic [dbab_pkg::CNT_W-1:0]      eff_samples_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]      uniform_weight_i,
  input  wire logic [dbab_pkg::WGT_W-1:0]      profile_weight_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]      ext_separation_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]      ext_artifact_i,
  input  wire logic [dbab_pkg::FAC_W-1:0]      ext_registration_i,
  input  wire logic                            last_channel_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [dbab_pkg::FAC_W-1:0]      alpha_o,
  output logic                                 none_active_o
);

  dbab_pkg::dbab_cmd_t    cmd;
  dbab_pkg::dbab_status_t status;

  // sequencer
  dbab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  dbab_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .profile_support_i  (profile_support_i),
    .uniform_support_i  (uniform_support_i),
    .eff_samples_i      (eff_samples_i),
    .uniform_weight_i   (uniform_weight_i),
    .profile_weight_i   (profile_weight_i),
    .ext_separation_i   (ext_separation_i),
    .ext_artifact_i     (ext_artifact_i),
    .ext_registration_i (ext_registration_i),
    .last_channel_i     (last_channel_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .alpha_o            (alpha_o),
    .none_active_o      (none_active_o)
  );

  // no active channel always yields zero alpha
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_active_o |-> alpha_o == '0)
    else $error("none_active with nonzero alpha");

  // alpha never exceeds one
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alpha_o <= dbab_pkg::ONE_Q16)
    else $error("alpha above one");

  // divider is quiet whenever a new beat may enter
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.div_busy)
    else $error("divider busy while idle");

  // a result only overwrites a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending beat");

  // a folded channel marks the pixel active
  a_any_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> status.any_active)
    else $error("active flag not set after update");

endmodule

`default_nettype wire
